// File: src/tlsh_pkg.sv
// Package for the two-axis limit switch homing block.
// Holds the sequencer phase type, command, axis and register codes, and reset values.
// No dependencies.
package tlsh_pkg;

  localparam int unsigned SPEED_W = 7;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned DRIVE_W = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SPEED_W-1:0] SPEED_LIMIT = 7'd100;

  localparam logic [SPEED_W-1:0] FAST_SPEED_RST    = 7'd25;
  localparam logic [SPEED_W-1:0] SLOW_SPEED_RST    = 7'd10;
  localparam logic [TICKS_W-1:0] BACKOFF_TICKS_RST = 16'd1000;
  localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST  = 16'd50;

  localparam logic [CFG_IDX_W-1:0] REG_FAST_SPEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS  = 2'd3;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BACKOFF = 3'd1,
    PH_FAST    = 3'd2,
    PH_SETTLE  = 3'd3,
    PH_RETREAT = 3'd4,
    PH_CREEP   = 3'd5
  } phase_t;

endpackage

// File: src/two_axis_limit_switch_homing.sv
// Top level of the two-axis limit switch homing sequencer.
// Depends on tlsh_pkg for the phase type, codes and register reset values.
//
// Each transfer on the input channel is either a tick or a start command together with both
// limit switch samples, and it yields exactly one result transfer showing both axis drives,
// the busy flag and a one-item homed pulse. An item is taken every cycle unless a result is
// stalled: the sequencer state update is a single registered step from the accepted item to
// the result register, so an item's result is offered on the cycle after its transfer, and a
// new item is accepted while that result is still waiting as long as out_ready is high.
// Configuration registers should be written only while no result is outstanding.
module two_axis_limit_switch_homing
  import tlsh_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic                      in_switch_x,
  input  logic                      in_switch_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DRIVE_W-1:0] out_drive_x,
  output logic signed [DRIVE_W-1:0] out_drive_y,
  output logic                      out_busy_res,
  output logic                      out_homed
);

  logic [SPEED_W-1:0] fast_speed_r;
  logic [SPEED_W-1:0] slow_speed_r;
  logic [TICKS_W-1:0] backoff_ticks_r;
  logic [TICKS_W-1:0] settle_ticks_r;

  phase_t                 phase_r, phase_nxt;
  logic                   axis_r, axis_nxt;
  logic [TIMER_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [TIMER_WIDTH-1:0] cnt_dec;
  logic [TIMER_WIDTH-1:0] backoff_load;
  logic [TIMER_WIDTH-1:0] settle_load;
  logic                   backoff_nz;
  logic                   settle_nz;
  logic                   sw;
  logic                   homed_nxt;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_x_r, drive_x_nxt;
  logic signed [DRIVE_W-1:0] drive_y_r, drive_y_nxt;
  logic                      busy_r, busy_nxt;
  logic                      homed_r;

  logic [SPEED_W-1:0]        fast_clamp;
  logic [SPEED_W-1:0]        slow_clamp;
  logic signed [DRIVE_W-1:0] drive;

  logic in_xfer;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_speed_r    <= FAST_SPEED_RST;
      slow_speed_r    <= SLOW_SPEED_RST;
      backoff_ticks_r <= BACKOFF_TICKS_RST;
      settle_ticks_r  <= SETTLE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAST_SPEED:    fast_speed_r    <= cfg_data[SPEED_W-1:0];
        REG_SLOW_SPEED:    slow_speed_r    <= cfg_data[SPEED_W-1:0];
        REG_BACKOFF_TICKS: backoff_ticks_r <= cfg_data[TICKS_W-1:0];
        REG_SETTLE_TICKS:  settle_ticks_r  <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Loaded counts saturate when the timer is narrower than the tick registers.
  if (TIMER_WIDTH >= TICKS_W) begin : g_load_wide
    assign backoff_load = TIMER_WIDTH'(backoff_ticks_r);
    assign settle_load  = TIMER_WIDTH'(settle_ticks_r);
  end else begin : g_load_narrow
    assign backoff_load = (|backoff_ticks_r[TICKS_W-1:TIMER_WIDTH]) ? '1 :
                          backoff_ticks_r[TIMER_WIDTH-1:0];
    assign settle_load  = (|settle_ticks_r[TICKS_W-1:TIMER_WIDTH]) ? '1 :
                          settle_ticks_r[TIMER_WIDTH-1:0];
  end

  assign backoff_nz = |backoff_ticks_r;
  assign settle_nz  = |settle_ticks_r;
  assign cnt_dec    = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
  assign sw         = (axis_r == AXIS_Y) ? in_switch_y : in_switch_x;

  always_comb begin
    phase_nxt = phase_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    homed_nxt = 1'b0;
    if (in_command == CMD_START) begin
      if (phase_r == PH_IDLE) begin
        priority if (in_switch_x && backoff_nz) begin
          phase_nxt = PH_BACKOFF;
          axis_nxt  = AXIS_X;
          cnt_nxt   = backoff_load;
        end else if (in_switch_y && backoff_nz) begin
          phase_nxt = PH_BACKOFF;
          axis_nxt  = AXIS_Y;
          cnt_nxt   = backoff_load;
        end else begin
          phase_nxt = PH_FAST;
          axis_nxt  = AXIS_X;
          cnt_nxt   = '0;
        end
      end
    end else begin
      unique case (phase_r)
        PH_BACKOFF: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            if (axis_r == AXIS_X && in_switch_y && backoff_nz) begin
              axis_nxt = AXIS_Y;
              cnt_nxt  = backoff_load;
            end else begin
              phase_nxt = PH_FAST;
              axis_nxt  = AXIS_X;
              cnt_nxt   = '0;
            end
          end
        end
        PH_FAST: begin
          if (sw) begin
            if (settle_nz) begin
              phase_nxt = PH_SETTLE;
              cnt_nxt   = settle_load;
            end else begin
              phase_nxt = PH_RETREAT;
            end
          end
        end
        PH_SETTLE: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            phase_nxt = PH_RETREAT;
          end
        end
        PH_RETREAT: begin
          if (!sw) begin
            phase_nxt = PH_CREEP;
          end
        end
        PH_CREEP: begin
          if (sw) begin
            if (axis_r == AXIS_X) begin
              phase_nxt = PH_FAST;
              axis_nxt  = AXIS_Y;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = PH_IDLE;
              axis_nxt  = AXIS_X;
              cnt_nxt   = '0;
              homed_nxt = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  assign fast_clamp = (fast_speed_r > SPEED_LIMIT) ? SPEED_LIMIT : fast_speed_r;
  assign slow_clamp = (slow_speed_r > SPEED_LIMIT) ? SPEED_LIMIT : slow_speed_r;

  always_comb begin
    unique case (phase_nxt)
      PH_BACKOFF: drive = -$signed({1'b0, fast_clamp});
      PH_FAST:    drive = $signed({1'b0, fast_clamp});
      PH_RETREAT: drive = -$signed({1'b0, slow_clamp});
      PH_CREEP:   drive = $signed({1'b0, slow_clamp});
      default:    drive = '0;
    endcase
    drive_x_nxt = (axis_nxt == AXIS_X) ? drive : '0;
    drive_y_nxt = (axis_nxt == AXIS_Y) ? drive : '0;
    busy_nxt    = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      axis_r      <= AXIS_X;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r <= phase_nxt;
        axis_r  <= axis_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      drive_x_r <= drive_x_nxt;
      drive_y_r <= drive_y_nxt;
      busy_r    <= busy_nxt;
      homed_r   <= homed_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_drive_x  = drive_x_r;
  assign out_drive_y  = drive_y_r;
  assign out_busy_res = busy_r;
  assign out_homed    = homed_r;

endmodule

// File: src/tlsh_checker.sv
// Port-level checker for the two-axis limit switch homing block, with its bind statement.
// Depends on tlsh_pkg for field widths; attaches to two_axis_limit_switch_homing.
module tlsh_checker
  import tlsh_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DRIVE_W-1:0] out_drive_x,
  input logic signed [DRIVE_W-1:0] out_drive_y,
  input logic                      out_busy_res,
  input logic                      out_homed
);

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_x) && $stable(out_drive_y)
      && $stable(out_busy_res) && $stable(out_homed))
    else $error("result changed while stalled");

  // Completing the sequence leaves the block idle.
  a_homed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_homed |-> !out_busy_res)
    else $error("homed pulse while busy");

  // No axis moves while idle.
  a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_drive_x == '0 && out_drive_y == '0)
    else $error("drive while idle");

  // Only one axis is driven at a time.
  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_x == '0 || out_drive_y == '0)
    else $error("both axes driven");

  // Drive magnitude never exceeds the speed limit.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_x <= 8'sd100 && out_drive_x >= -8'sd100
      && out_drive_y <= 8'sd100 && out_drive_y >= -8'sd100)
    else $error("drive out of range");

endmodule

bind two_axis_limit_switch_homing tlsh_checker u_tlsh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_drive_x  (out_drive_x),
  .out_drive_y  (out_drive_y),
  .out_busy_res (out_busy_res),
  .out_homed    (out_homed)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the two-axis limit switch homing sequencer.
// Drives a directed table and then closed-loop homing passes against a simple switch plant,
// checking each result against a local model or typed row; depends on tlsh_pkg and the RTL.
module tb_top;
  import tlsh_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PLANT_CAP = 120;
  localparam int unsigned NUM_PHASES = 11;
  localparam int POS_MIN = -40;
  localparam int POS_MAX = 5;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_x;
    logic signed [DRIVE_W-1:0] drive_y;
    logic                      busy;
    logic                      homed;
  } homing_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 cmd;
    logic                 sx;
    logic                 sy;
    logic                 typed;
    homing_result_t       res;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_data;
  } stim_row_t;

  localparam homing_result_t IDLE_RES  = '0;
  localparam homing_result_t HOMED_RES = '{8'sd0, 8'sd0, 1'b0, 1'b1};
  localparam homing_result_t BACK_X    = '{-8'sd100, 8'sd0, 1'b1, 1'b0};
  localparam homing_result_t STOP_BUSY = '{8'sd0, 8'sd0, 1'b1, 1'b0};

  localparam int unsigned DIRECTED_ROWS = 31;
  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b0, 1'b1, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_CFG,  CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd127},
    '{ROW_CFG,  CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_SLOW_SPEED,    16'd100},
    '{ROW_CFG,  CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_BACKOFF_TICKS, 16'd2},
    '{ROW_CFG,  CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_SETTLE_TICKS,  16'd1},
    '{ROW_ITEM, CMD_START, 1'b1, 1'b1, 1'b1, BACK_X,    REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_START, 1'b0, 1'b0, 1'b1, BACK_X,    REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b1, 1'b1, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b1, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b1, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b1, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b1, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b1, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b1, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b1, 1'b1, HOMED_RES, REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b1, 1'b1, 1'b1, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_CFG,  CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_BACKOFF_TICKS, 16'd0},
    '{ROW_CFG,  CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_SETTLE_TICKS,  16'd0},
    '{ROW_CFG,  CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_CFG,  CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_SLOW_SPEED,    16'd1},
    '{ROW_ITEM, CMD_START, 1'b1, 1'b1, 1'b1, STOP_BUSY, REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b1, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b1, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b1, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b0, 1'b0, IDLE_RES,  REG_FAST_SPEED,    16'd0},
    '{ROW_ITEM, CMD_TICK,  1'b0, 1'b1, 1'b1, HOMED_RES, REG_FAST_SPEED,    16'd0}
  };

  logic                      clk;
  logic                      rst_n       = 1'b0;
  logic                      cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index   = REG_FAST_SPEED;
  logic [CFG_W-1:0]          cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic                      in_command  = CMD_TICK;
  logic                      in_switch_x = 1'b0;
  logic                      in_switch_y = 1'b0;
  logic                      out_valid;
  logic                      out_ready   = 1'b1;
  logic signed [DRIVE_W-1:0] out_drive_x;
  logic signed [DRIVE_W-1:0] out_drive_y;
  logic                      out_busy_res;
  logic                      out_homed;

  two_axis_limit_switch_homing u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_switch_x  (in_switch_x),
    .in_switch_y  (in_switch_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_drive_x  (out_drive_x),
    .out_drive_y  (out_drive_y),
    .out_busy_res (out_busy_res),
    .out_homed    (out_homed)
  );

  // Local copy of the sequencer state and registers.
  phase_t             hm_phase = PH_IDLE;
  logic               hm_axis  = AXIS_X;
  logic [TICKS_W-1:0] hm_count = '0;
  logic [SPEED_W-1:0] cf_fast    = FAST_SPEED_RST;
  logic [SPEED_W-1:0] cf_slow    = SLOW_SPEED_RST;
  logic [TICKS_W-1:0] cf_backoff = BACKOFF_TICKS_RST;
  logic [TICKS_W-1:0] cf_settle  = SETTLE_TICKS_RST;

  homing_result_t pending_results[$];
  homing_result_t last_result;
  homing_result_t typed_result;
  logic           use_typed = 1'b0;
  logic           in_taken  = 1'b0;
  int unsigned    send_pct  = 0;
  int unsigned    recv_pct  = 0;
  int unsigned    mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic advance_homing(input logic cmd, input logic sx, input logic sy,
                                output homing_result_t res);
    logic                      sw;
    logic                      homed;
    logic [SPEED_W-1:0]        mag;
    logic signed [DRIVE_W-1:0] drive;
    homed = 1'b0;
    if (cmd == CMD_START) begin
      if (hm_phase == PH_IDLE) begin
        if (sx && cf_backoff != 0) begin
          hm_phase = PH_BACKOFF;
          hm_axis  = AXIS_X;
          hm_count = cf_backoff;
        end else if (sy && cf_backoff != 0) begin
          hm_phase = PH_BACKOFF;
          hm_axis  = AXIS_Y;
          hm_count = cf_backoff;
        end else begin
          hm_phase = PH_FAST;
          hm_axis  = AXIS_X;
          hm_count = '0;
        end
      end
    end else begin
      sw = (hm_axis == AXIS_Y) ? sy : sx;
      case (hm_phase)
        PH_BACKOFF: begin
          if (hm_count != 0) hm_count = hm_count - 1'b1;
          if (hm_count == 0) begin
            if (hm_axis == AXIS_X && sy && cf_backoff != 0) begin
              hm_axis  = AXIS_Y;
              hm_count = cf_backoff;
            end else begin
              hm_phase = PH_FAST;
              hm_axis  = AXIS_X;
            end
          end
        end
        PH_FAST: begin
          if (sw) begin
            if (cf_settle != 0) begin
              hm_phase = PH_SETTLE;
              hm_count = cf_settle;
            end else begin
              hm_phase = PH_RETREAT;
            end
          end
        end
        PH_SETTLE: begin
          if (hm_count != 0) hm_count = hm_count - 1'b1;
          if (hm_count == 0) hm_phase = PH_RETREAT;
        end
        PH_RETREAT: begin
          if (!sw) hm_phase = PH_CREEP;
        end
        PH_CREEP: begin
          if (sw) begin
            if (hm_axis == AXIS_X) begin
              hm_phase = PH_FAST;
              hm_axis  = AXIS_Y;
              hm_count = '0;
            end else begin
              hm_phase = PH_IDLE;
              hm_axis  = AXIS_X;
              hm_count = '0;
              homed    = 1'b1;
            end
          end
        end
        default: hm_phase = PH_IDLE;
      endcase
    end

    if (hm_phase == PH_BACKOFF || hm_phase == PH_FAST) mag = cf_fast;
    else mag = cf_slow;
    if (mag > SPEED_LIMIT) mag = SPEED_LIMIT;
    drive = $signed({1'b0, mag});
    case (hm_phase)
      PH_BACKOFF, PH_RETREAT: drive = -drive;
      PH_FAST, PH_CREEP:      drive = drive;
      default:                drive = '0;
    endcase
    res.drive_x = (hm_axis == AXIS_X) ? drive : '0;
    res.drive_y = (hm_axis == AXIS_Y) ? drive : '0;
    res.busy    = (hm_phase != PH_IDLE);
    res.homed   = homed;
  endtask

  // Clock step: check a result transfer, predict an input transfer, then pick out_ready.
  task automatic step_clock();
    homing_result_t got;
    homing_result_t want;
    homing_result_t calc;
    @(posedge clk);
    if (out_valid && out_ready) begin
      got = '{out_drive_x, out_drive_y, out_busy_res, out_homed};
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", int'(got), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.drive_x !== want.drive_x) begin
          report_mismatch("drive_x", int'(got.drive_x), int'(want.drive_x));
        end
        if (got.drive_y !== want.drive_y) begin
          report_mismatch("drive_y", int'(got.drive_y), int'(want.drive_y));
        end
        if (got.busy !== want.busy) report_mismatch("busy_res", int'(got.busy), int'(want.busy));
        if (got.homed !== want.homed) report_mismatch("homed", int'(got.homed), int'(want.homed));
      end
    end
    in_taken = in_valid && in_ready;
    if (in_taken) begin
      advance_homing(in_command, in_switch_x, in_switch_y, calc);
      last_result = calc;
      pending_results.push_back(use_typed ? typed_result : calc);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_pct);
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 82; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 82; end
      default:   begin send_pct = 12; recv_pct = 12; end
    endcase
  endtask

  task automatic send_item(logic cmd, logic sx, logic sy);
    cfg_we <= 1'b0;
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do step_clock(); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_switch_x <= sx;
    in_switch_y <= sy;
    do step_clock(); while (!in_taken);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) step_clock();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    step_clock();
    case (idx)
      REG_FAST_SPEED:    cf_fast    = data[SPEED_W-1:0];
      REG_SLOW_SPEED:    cf_slow    = data[SPEED_W-1:0];
      REG_BACKOFF_TICKS: cf_backoff = data[TICKS_W-1:0];
      REG_SETTLE_TICKS:  cf_settle  = data[TICKS_W-1:0];
      default:           cf_fast    = cf_fast;
    endcase
  endtask

  function automatic logic [SPEED_W-1:0] rand_speed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SPEED_LIMIT;
      2:       return SPEED_LIMIT + 1'b1;
      3:       return '1;
      default: return SPEED_W'($urandom_range(0, 127));
    endcase
  endfunction

  // One homing pass against a plant in which a switch is pressed at position zero and above.
  task automatic run_homing_pass(logic force_x);
    int          pos_x;
    int          pos_y;
    int unsigned n;
    logic        cmd;
    logic        sx;
    logic        sy;
    if (force_x) begin
      pos_x = 0;
      pos_y = -10;
    end else begin
      pos_x = $urandom_range(0, 18);
      pos_x = pos_x - 15;
      pos_y = $urandom_range(0, 18);
      pos_y = pos_y - 15;
    end
    n = 0;
    do begin
      cmd = (n == 0 || $urandom_range(0, 39) == 0) ? CMD_START : CMD_TICK;
      if (n > PLANT_CAP) begin
        sx = 1'($urandom_range(0, 1));
        sy = 1'($urandom_range(0, 1));
      end else begin
        sx = (pos_x >= 0) ^ ($urandom_range(0, 24) == 0);
        sy = (pos_y >= 0) ^ ($urandom_range(0, 24) == 0);
      end
      send_item(cmd, sx, sy);
      n++;
      if (last_result.drive_x > 0 && pos_x < POS_MAX) pos_x++;
      if (last_result.drive_x < 0 && pos_x > POS_MIN) pos_x--;
      if (last_result.drive_y > 0 && pos_y < POS_MAX) pos_y++;
      if (last_result.drive_y < 0 && pos_y > POS_MIN) pos_y--;
    end while (hm_phase != PH_IDLE);
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [SPEED_W-1:0] fast;
    logic [SPEED_W-1:0] slow;
    logic [TICKS_W-1:0] backoff;
    logic [TICKS_W-1:0] settle;
    logic [CFG_W-1:0]   junk;
    idle_mode_t         mode;
    int unsigned        passes;
    logic               force_x;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_data);
      end else begin
        use_typed    = DIRECTED[r].typed;
        typed_result = DIRECTED[r].res;
        send_item(DIRECTED[r].cmd, DIRECTED[r].sx, DIRECTED[r].sy);
        use_typed    = 1'b0;
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      force_x = 1'b0;
      passes  = 3;
      case (p)
        0: begin
          fast = FAST_SPEED_RST; slow = SLOW_SPEED_RST;
          backoff = 16'd40; settle = SETTLE_TICKS_RST;
          mode = IDLE_NONE; passes = 2;
        end
        1: begin
          fast = SPEED_LIMIT; slow = SPEED_LIMIT; backoff = 16'd30; settle = 16'd2;
          mode = IDLE_NONE; passes = 1; force_x = 1'b1;
        end
        2: begin
          fast = '1; slow = '1; backoff = 16'd2; settle = 16'd30;
          mode = IDLE_NONE; passes = 1;
        end
        default: begin
          fast = rand_speed(); slow = rand_speed();
          backoff = TICKS_W'($urandom_range(0, 12)); settle = TICKS_W'($urandom_range(0, 12));
          mode = idle_mode_t'((p - 2) % 4);
        end
      endcase
      set_idling(mode);
      junk = CFG_W'($urandom);
      write_reg(REG_FAST_SPEED, {junk[CFG_W-1:SPEED_W], fast});
      junk = CFG_W'($urandom);
      write_reg(REG_SLOW_SPEED, {junk[CFG_W-1:SPEED_W], slow});
      write_reg(REG_BACKOFF_TICKS, backoff);
      write_reg(REG_SETTLE_TICKS, settle);
      repeat (passes) begin
        if (!force_x) begin
          repeat ($urandom_range(0, 5)) begin
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          end
        end
        run_homing_pass(force_x);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) step_clock();
    repeat (4) step_clock();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
